[hw/rtl/imctf_pkg.sv]
package imctf_pkg;

    // cordic datapath widths: inputs scaled by 256, angles in Q29
    localparam int XW = 27;
    localparam int ZW = 32;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ZW-1:0] PI_HALF_Q29 = 32'sd843314857;
    localparam logic signed [15:0]   PI_Q12      = 16'sd12868;

    // atan(2^-i) in Q29
    localparam logic signed [ZW-1:0] ATAN_Q29 [ATAN_LEN] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    // one vector travelling down the cordic chain
    typedef struct packed {
        logic                 vld;
        logic                 tag;   // 0 roll, 1 pitch
        logic                 zero;  // atan2(0,0)
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

endpackage

[hw/rtl/imctf_cell.sv]
module imctf_cell
    import imctf_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cordic_t c_in,
    output cordic_t c_out
);

    cordic_t c_next;
    cordic_t c_reg;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    // one vectoring micro-rotation
    always_comb begin
        dx = $signed(c_in.y) >>> STEP;
        dy = $signed(c_in.x) >>> STEP;
        c_next = c_in;
        if (!c_in.y[XW-1]) begin
            c_next.x = c_in.x + dx;
            c_next.y = c_in.y - dy;
            c_next.z = c_in.z + ATAN_Q29[STEP];
        end else begin
            c_next.x = c_in.x - dx;
            c_next.y = c_in.y + dy;
            c_next.z = c_in.z - ATAN_Q29[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.vld <= 1'b0;
        end else begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

[hw/rtl/imu_tilt_complementary_filter.sv]
// imu tilt complementary filter: roll and pitch from one imu sample
// s_axis: one transfer per sample, tdata = accel_x, accel_y, accel_z,
//   rate_roll, rate_pitch (16 bit signed each, lowest bits first)
// m_axis: one transfer per sample, tdata = roll_angle, pitch_angle
//   (15 bit signed q3.12 radians each), two zero pad bits on top
// cfg port: index 0 blend_weight (q0.16 gyro weight), index 1 step_time
//   (q0.16 seconds); write only while the block is idle
// accelerometer angles come from a chain of CORDIC_STEPS cordic cells;
// roll enters the chain right after the transfer, pitch after a 24-step
// bit-by-bit square root of ay^2 + az^2
// work per sample, in order: the squares of ay and az, 24 root steps, the
// cordic chain and the wait for the pitch angle, the filter phases with
// one multiplier for roll and then pitch, and the output load; one sample
// is in work at a time, and s_axis_tready is high whenever no sample is in
// work, so a new sample may enter while the last result still waits in the
// output register
// a stalled receiver holds the result; the next result waits at the end
// of its work until the output register frees
// reset (aresetn, synchronous, active low) clears both estimates, restores
// the register defaults and empties the chain
module imu_tilt_complementary_filter
    import imctf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // accel_x, accel_y, accel_z, rate_roll, rate_pitch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // roll_angle, pitch_angle, 2 zero bits
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQA  = 3'd1;
    localparam logic [2:0] ST_SQB  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_FILT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [1:0] REG_BLEND = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;

    localparam logic [4:0] ROOT_LAST = 5'd23;
    localparam logic [2:0] FPH_LAST  = 3'd4;

    // pre-rotation into the right half plane
    function automatic cordic_t prerot(input logic signed [XW-1:0] y,
                                       input logic signed [XW-1:0] x,
                                       input logic tag);
        cordic_t c;
        c.vld  = 1'b1;
        c.tag  = tag;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (x[XW-1]) begin
            if (!y[XW-1]) begin
                c.x = y;
                c.y = -x;
                c.z = PI_HALF_Q29;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -PI_HALF_Q29;
            end
        end
        return c;
    endfunction

    logic [2:0]  state_reg;
    logic [15:0] blend_reg;
    logic [15:0] step_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gr_reg, gp_reg;
    logic signed [15:0] roll_est_reg, pitch_est_reg;
    logic signed [15:0] roll_acc_reg, pitch_acc_reg;
    logic               roll_done_reg, pitch_done_reg;

    logic [31:0] sq_reg;
    logic [47:0] rem_reg, root_reg;
    logic [47:0] rem_next, root_next, root_bit;
    logic [48:0] trial;
    logic [4:0]  k_reg;

    logic               axis_reg;
    logic [2:0]         fph_reg;
    logic signed [32:0] prod_reg;
    logic signed [18:0] pred_reg;
    logic signed [37:0] m1_reg;
    logic signed [33:0] m2_reg;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;

    cordic_t link [CORDIC_STEPS+1];
    cordic_t launch;
    logic signed [15:0] chain_ang;
    logic signed [ZW:0] z_rnd;

    logic               in_xfer;
    logic               root_end;
    logic signed [15:0] rate_sel, est_sel, acc_sel;
    logic signed [32:0] prod_rnd;
    logic signed [18:0] pred_next;
    logic signed [37:0] sum_next;
    logic signed [21:0] r_next;
    logic signed [15:0] r_sat;
    logic signed [17:0] acc_w;
    logic signed [XW-1:0] ax_neg;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign root_end      = (state_reg == ST_ROOT) && (k_reg == ROOT_LAST);

    // one root step: bit walks from 2^46 down by powers of four
    always_comb begin
        root_bit  = 48'd1 << (6'd46 - {k_reg, 1'b0});
        trial     = {1'b0, root_reg} + {1'b0, root_bit};
        rem_next  = rem_reg;
        root_next = root_reg >> 1;
        if ({1'b0, rem_reg} >= trial) begin
            rem_next  = rem_reg - trial[47:0];
            root_next = (root_reg >> 1) + root_bit;
        end
    end

    // chain entry: roll at the input transfer, pitch at the last root step
    always_comb begin
        ax_neg = -(XW'(ax_reg) <<< 8);
        launch = '0;
        if (in_xfer) begin
            launch = prerot(XW'($signed(s_axis_tdata[31:16])) <<< 8,
                            XW'($signed(s_axis_tdata[47:32])) <<< 8, 1'b0);
        end else if (root_end) begin
            launch = prerot(ax_neg, $signed({3'b000, root_next[23:0]}), 1'b1);
        end
    end

    assign link[0] = launch;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
            imctf_cell #(.STEP(gi)) u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .c_in   (link[gi]),
                .c_out  (link[gi+1])
            );
        end
    endgenerate

    // q29 to q3.12, round half up
    assign z_rnd     = $signed({link[CORDIC_STEPS].z[ZW-1], link[CORDIC_STEPS].z})
                       + (ZW+1)'(65536);
    assign chain_ang = link[CORDIC_STEPS].zero ? 16'sd0 : z_rnd[32:17];

    // filter datapath, at most one multiplier per phase
    always_comb begin
        rate_sel  = axis_reg ? gp_reg : gr_reg;
        est_sel   = axis_reg ? pitch_est_reg : roll_est_reg;
        acc_sel   = axis_reg ? pitch_acc_reg : roll_acc_reg;
        acc_w     = 18'sd65536 - $signed({2'b00, blend_reg});
        prod_rnd  = prod_reg + 33'sd16384;
        pred_next = 19'(est_sel) + 19'($signed(prod_rnd[32:15]));
        sum_next  = m1_reg + 38'(m2_reg) + 38'sd32768;
        r_next    = sum_next[37:16];
        if (r_next > 22'(PI_Q12)) begin
            r_sat = PI_Q12;
        end else if (r_next < -22'(PI_Q12)) begin
            r_sat = -PI_Q12;
        end else begin
            r_sat = r_next[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (fph_reg)
            3'd0:    prod_reg <= rate_sel * $signed({1'b0, step_reg});
            3'd1:    pred_reg <= pred_next;
            3'd2:    m1_reg   <= 38'($signed({1'b0, blend_reg}) * pred_reg);
            3'd3:    m2_reg   <= acc_w * acc_sel;
            default: ;
        endcase
        if (in_xfer) begin
            ax_reg <= $signed(s_axis_tdata[15:0]);
            ay_reg <= $signed(s_axis_tdata[31:16]);
            az_reg <= $signed(s_axis_tdata[47:32]);
            gr_reg <= $signed(s_axis_tdata[63:48]);
            gp_reg <= $signed(s_axis_tdata[79:64]);
        end
        case (state_reg)
            ST_SQA:  sq_reg <= 32'(ay_reg * ay_reg);
            ST_SQB: begin
                rem_reg  <= {sq_reg + 32'(az_reg * az_reg), 16'h0000};
                root_reg <= '0;
            end
            ST_ROOT: begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
            default: ;
        endcase
        if (link[CORDIC_STEPS].vld) begin
            if (link[CORDIC_STEPS].tag) begin
                pitch_acc_reg <= chain_ang;
            end else begin
                roll_acc_reg <= chain_ang;
            end
        end
    end

    // control and kept state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            blend_reg      <= 16'd61604;
            step_reg       <= 16'd1311;
            roll_est_reg   <= '0;
            pitch_est_reg  <= '0;
            roll_done_reg  <= 1'b0;
            pitch_done_reg <= 1'b0;
            k_reg          <= '0;
            axis_reg       <= 1'b0;
            fph_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BLEND: blend_reg <= cfg_wdata;
                    REG_STEP:  step_reg  <= cfg_wdata;
                    default:   ;
                endcase
            end
            // in the done state the output load below owns the valid flag
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (link[CORDIC_STEPS].vld) begin
                if (link[CORDIC_STEPS].tag) begin
                    pitch_done_reg <= 1'b1;
                end else begin
                    roll_done_reg <= 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        roll_done_reg  <= 1'b0;
                        pitch_done_reg <= 1'b0;
                        state_reg      <= ST_SQA;
                    end
                end
                ST_SQA: state_reg <= ST_SQB;
                ST_SQB: begin
                    k_reg     <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    k_reg <= k_reg + 5'd1;
                    if (root_end) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (roll_done_reg && pitch_done_reg) begin
                        axis_reg  <= 1'b0;
                        fph_reg   <= '0;
                        state_reg <= ST_FILT;
                    end
                end
                ST_FILT: begin
                    fph_reg <= fph_reg + 3'd1;
                    if (fph_reg == FPH_LAST) begin
                        fph_reg <= '0;
                        if (axis_reg) begin
                            pitch_est_reg <= r_sat;
                            state_reg     <= ST_DONE;
                        end else begin
                            roll_est_reg <= r_sat;
                            axis_reg     <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, pitch_est_reg[14:0], roll_est_reg[14:0]};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == ST_SQA)
        else $error("input transfer did not start the square step");
    a_filt_has_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILT |-> roll_done_reg && pitch_done_reg)
        else $error("filter running without both accelerometer angles");
    a_est_range: assert property (@(posedge aclk) disable iff (!aresetn)
        roll_est_reg <= PI_Q12 && roll_est_reg >= -PI_Q12
        && pitch_est_reg <= PI_Q12 && pitch_est_reg >= -PI_Q12)
        else $error("estimate beyond pi");
`endif

endmodule

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int PI_Q12 = 12868;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int REG_BLEND = 0;
    localparam int REG_STEP = 1;
    localparam int REG_UNUSED = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    // tilt predictor plus a queue of expected angle pairs
    class tilt_board;
        int unsigned alpha = 61604;
        int unsigned dt = 1311;
        longint roll_est = 0;
        longint pitch_est = 0;
        logic [29:0] pending[$];
        int errors = 0;
        int checked = 0;

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint rnd_shr(longint v, int s);
            return floor_shr(v + (longint'(1) << (s - 1)), s);
        endfunction

        function longint int_root(longint n);
            longint rem, root, bit_v;
            rem = n; root = 0; bit_v = longint'(1) << 46;
            while (bit_v != 0) begin
                if (rem >= root + bit_v) begin
                    rem -= root + bit_v;
                    root = (root >> 1) + bit_v;
                end else begin
                    root = root >> 1;
                end
                bit_v = bit_v >> 2;
            end
            return root;
        endfunction

        function longint angle_of(longint y_in, longint x_in);
            longint atan_tab[24] = '{421657428, 248918915, 131521918, 66762579,
                33510843, 16771758, 8387925, 4194219, 2097141, 1048575, 524288,
                262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                512, 256, 128, 64};
            longint x, y, z, t, dx, dy;
            x = x_in; y = y_in; z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 843314857;
                end else begin
                    x = -y; y = t; z = -843314857;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = floor_shr(y, i); dy = floor_shr(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_tab[i];
                end else begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
            end
            return rnd_shr(z, 17);
        endfunction

        function longint blend_axis(longint est, longint rate, longint acc_ang);
            longint inc, r;
            inc = rnd_shr(rate * longint'(dt), 15);
            r = rnd_shr(longint'(alpha) * (est + inc)
                + longint'(65536 - alpha) * acc_ang, 16);
            if (r > PI_Q12) r = PI_Q12;
            if (r < -PI_Q12) r = -PI_Q12;
            return r;
        endfunction

        function void write_reg(int idx, int unsigned val);
            if (idx == REG_BLEND) alpha = val & 16'hffff;
            else if (idx == REG_STEP) dt = val & 16'hffff;
        endfunction

        function void note_sample(logic [79:0] d);
            longint ax, ay, az, gr, gp, mag;
            logic [14:0] r15, p15;
            ax = longint'($signed(d[15:0]));
            ay = longint'($signed(d[31:16]));
            az = longint'($signed(d[47:32]));
            gr = longint'($signed(d[63:48]));
            gp = longint'($signed(d[79:64]));
            mag = int_root((ay * ay + az * az) << 16);
            roll_est = blend_axis(roll_est, gr, angle_of(ay * 256, az * 256));
            pitch_est = blend_axis(pitch_est, gp, angle_of(-ax * 256, mag));
            r15 = roll_est[14:0];
            p15 = pitch_est[14:0];
            pending.push_back({p15, r15});
        endfunction

        function void check_result(logic [31:0] d);
            logic [29:0] exp_v;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, d);
                return;
            end
            exp_v = pending.pop_front();
            if (d[14:0] != exp_v[14:0])
                report_mismatch("roll_angle", exp_v[14:0], d[14:0]);
            if (d[29:15] != exp_v[29:15])
                report_mismatch("pitch_angle", exp_v[29:15], d[29:15]);
            if (d[31:30] != 2'b00)
                report_mismatch("pad bits", 0, d[31:30]);
        endfunction

        function void report_mismatch(string what, int expv, int gotv);
            errors++;
            if (errors <= 30)
                $display("mismatch %s: expected %0d got %0d", what, expv, gotv);
        endfunction
    endclass

    tilt_board board = new();

    imu_tilt_complementary_filter #(.CORDIC_STEPS(STEPS)) dut (.*);

    always #2 aclk = ~aclk;

    int cycles = 0;
    bit quiet_src = 0;     // no idling on the sender
    bit quiet_sink = 0;    // no idling on the receiver
    bit hold_sink = 0;     // long receiver hold-off
    int samples_sent = 0;

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: random stalls, checks every transfer
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if (hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 10);
    end

    task automatic write_cfg(int idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx[1:0];
        cfg_wdata <= val[15:0];
        @(posedge aclk);
        board.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // send one sample, holding valid until the transfer; valid stays up
    // for a following sample and drops on idle cycles or in drain
    task automatic send_sample(logic [79:0] d);
        while (!quiet_src && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_sample(d);
        samples_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [79:0] rand_sample();
        logic [15:0] gr, gp;
        // mostly plausible gyro rates, sometimes full range
        if ($urandom_range(3) == 0) begin
            gr = pick16(); gp = pick16();
        end else begin
            gr = 16'($signed($urandom_range(8000)) - 4000);
            gp = 16'($signed($urandom_range(8000)) - 4000);
        end
        return {gp, gr, pick16(), pick16(), pick16()};
    endfunction

    initial begin
        int unsigned blends[5] = '{0, 65535, 61604, 32768, 1};
        int unsigned dts[5] = '{1, 65535, 1311, 655, 20000};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero vector, axis extremes, quadrants, gyro extremes
        send_sample('0);
        send_sample({16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        send_sample({16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000});
        send_sample({16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000});
        send_sample({16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000});
        send_sample({16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff});
        send_sample({16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h0000});
        send_sample({16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001});
        send_sample({16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff});
        send_sample({16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000});
        drain();
        // saturation: full gyro weight with long step
        write_cfg(REG_BLEND, 65535);
        write_cfg(REG_STEP, 65535);
        write_cfg(REG_UNUSED, 16'h1234);
        repeat (4) send_sample({16'h7fff, 16'h7fff, 16'h1000, 16'h0100, 16'h0100});
        repeat (4) send_sample({16'h8000, 16'h8000, 16'h1000, 16'h0100, 16'h0100});
        drain();
        write_cfg(REG_BLEND, 0);
        write_cfg(REG_STEP, 1);
        repeat (3) send_sample(rand_sample());
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 7; ph++) begin
            write_cfg(REG_BLEND, ph < 5 ? blends[ph] : $urandom_range(65535));
            write_cfg(REG_STEP, ph < 5 ? dts[ph] : $urandom_range(65535, 1));
            quiet_src = (ph == 3);
            quiet_sink = (ph == 3);
            for (int k = 0; k < 200; k++) begin
                if (ph == 2 && k == 50) begin
                    // long receiver hold-off while samples keep coming
                    fork
                        begin
                            hold_sink = 1;
                            repeat (600) @(posedge aclk);
                            hold_sink = 0;
                        end
                    join_none
                end
                if (ph == 4 && k == 100) drain();  // sender waits for all results
                send_sample(rand_sample());
            end
            drain();
        end
        quiet_src = 0;
        quiet_sink = 0;

        $display("sent %0d imu samples, checked %0d angle pairs over 10 register settings",
                 samples_sent, board.checked);
        $display("covered zero vector, axis extremes, saturation and stalls");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/imctf_pkg.sv
hw/rtl/imctf_cell.sv
hw/rtl/imu_tilt_complementary_filter.sv
dv/tb_top.sv
